@@ src/apqr_pkg.sv @@
package apqr_pkg;

  localparam int REQ_W  = 2;
  localparam int TIME_W = 32;
  localparam int NAME_W = 64;
  localparam int SEV_W  = 24;
  localparam int K_W    = 24;
  localparam int KIND_W = 2;
  localparam int PROD_W = K_W + TIME_W;   // k_rate * arrival_time
  localparam int PRIO_W = PROD_W + 2;     // signed, room for severity minus product

  // request codes
  localparam logic [REQ_W-1:0] REQ_ARRIVE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_SERVE  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_LEAVE  = 2'd2;

  // result kinds
  localparam logic [KIND_W-1:0] RES_SERVED = 2'd0;
  localparam logic [KIND_W-1:0] RES_EMPTY  = 2'd1;
  localparam logic [KIND_W-1:0] RES_FULL   = 2'd2;
  localparam logic [KIND_W-1:0] RES_DUP    = 2'd3;

  typedef struct packed {
    logic                     valid;
    logic signed [PRIO_W-1:0] prio;
    logic [NAME_W-1:0]        name;
  } entry_t;

  typedef struct packed {
    logic match;  // valid and same name as the broadcast key
    logic beat;   // broadcast key ranks ahead of this cell, or cell empty
  } cell_flags_t;

  typedef enum logic [1:0] {
    CMD_HOLD  = 2'd0,
    CMD_NEW   = 2'd1,
    CMD_LEFT  = 2'd2,
    CMD_RIGHT = 2'd3
  } cell_cmd_t;

  localparam entry_t ENTRY_NONE = '{valid: 1'b0, prio: '0, name: '0};

endpackage

@@ src/apqr_prio.sv @@
module apqr_prio import apqr_pkg::*; (
  input  logic                     clk,
  input  logic [K_W-1:0]           k_rate,
  input  logic [TIME_W-1:0]        arr_time,
  input  logic [SEV_W-1:0]         severity,
  output logic signed [PRIO_W-1:0] prio
);

  logic [PROD_W-1:0]        prod_r;
  logic signed [PRIO_W-1:0] prio_r;

  // two stages: product, then subtract
  always_ff @(posedge clk) begin
    prod_r <= PROD_W'(k_rate) * PROD_W'(arr_time);
    prio_r <= $signed({{(PRIO_W-SEV_W){1'b0}}, severity})
            - $signed({2'b00, prod_r});
  end

  assign prio = prio_r;

endmodule

@@ src/apqr_cell.sv @@
module apqr_cell import apqr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cell_cmd_t   cmd,
  input  entry_t      new_entry,
  input  entry_t      left_entry,
  input  entry_t      right_entry,
  output entry_t      entry,
  output cell_flags_t flags
);

  logic                     valid_r, valid_nxt;
  logic signed [PRIO_W-1:0] prio_r, prio_nxt;
  logic [NAME_W-1:0]        name_r, name_nxt;
  cell_flags_t              flags_r, flags_nxt;
  logic signed [PRIO_W-1:0] key_prio;

  assign key_prio = new_entry.prio;

  always_comb begin
    flags_nxt.match = valid_r && (name_r == new_entry.name);
    flags_nxt.beat  = !valid_r || (key_prio > prio_r) ||
                      ((key_prio == prio_r) && (new_entry.name < name_r));
  end

  always_comb begin
    valid_nxt = valid_r;
    prio_nxt  = prio_r;
    name_nxt  = name_r;
    case (cmd)
      CMD_NEW: begin
        valid_nxt = new_entry.valid;
        prio_nxt  = new_entry.prio;
        name_nxt  = new_entry.name;
      end
      CMD_LEFT: begin
        valid_nxt = left_entry.valid;
        prio_nxt  = left_entry.prio;
        name_nxt  = left_entry.name;
      end
      CMD_RIGHT: begin
        valid_nxt = right_entry.valid;
        prio_nxt  = right_entry.prio;
        name_nxt  = right_entry.name;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      flags_r <= '0;
    end else begin
      valid_r <= valid_nxt;
      flags_r <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    name_r <= name_nxt;
  end

  assign entry = '{valid: valid_r, prio: prio_r, name: name_r};
  assign flags = flags_r;

endmodule

@@ src/aging_priority_queue_with_removal.sv @@
// Channel   Direction  Handshake               Payload
// in_       in         in_valid / in_ready     req_type, arrival_time, patient_name, severity
// out_      out        out_valid / out_ready   result_kind, served_name
// cfg_      in         cfg_wr_en (no wait)     cfg_wr_data = k_rate
//
// One request at a time; after its transfer a request passes these steps before
// the next one can transfer: arrival multiply, subtract, compare and apply; leave
// compare, apply; serve apply; unused codes dropped. The aging multiplier pipe and
// the registered compare flags of the cell chain set these steps; occupancy does not matter.
// Reset (rst_n low, synchronous) empties every cell and clears k_rate.
// A result waiting on out_ready stalls the apply step of the next result-bearing request,
// and no request is taken in meanwhile; others still pass while the output register is full.
module aging_priority_queue_with_removal import apqr_pkg::*; #(
  parameter int CAPACITY = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [REQ_W-1:0]  in_req_type,
  input  logic [TIME_W-1:0] in_arrival_time,
  input  logic [NAME_W-1:0] in_patient_name,
  input  logic [SEV_W-1:0]  in_severity,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [KIND_W-1:0] out_result_kind,
  output logic [NAME_W-1:0] out_served_name,
  input  logic              cfg_wr_en,
  input  logic [K_W-1:0]    cfg_wr_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_MUL   = 5'b00010,
    S_SUB   = 5'b00100,
    S_CMP   = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  logic [K_W-1:0]    k_rate_r;
  logic [REQ_W-1:0]  req_r;
  logic [TIME_W-1:0] time_r;
  logic [NAME_W-1:0] name_r;
  logic [SEV_W-1:0]  sev_r;

  logic              out_valid_r;
  logic [KIND_W-1:0] out_kind_r, out_kind_nxt;
  logic [NAME_W-1:0] out_name_r, out_name_nxt;
  logic              out_load;

  logic signed [PRIO_W-1:0] new_prio;
  entry_t                   new_entry;

  // cell chain: cell 0 holds the best entry, valid cells are packed from 0
  entry_t        ent   [CAPACITY];
  cell_flags_t   flags [CAPACITY];
  cell_cmd_t     cmd   [CAPACITY];
  logic [CAPACITY-1:0] valid_vec, match_vec, beat_vec, beat_lag;

  logic accept, dup, full, need_result, blocked;
  logic do_insert, do_serve, do_leave;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == S_IDLE);

  // ---- config and request latch ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_rate_r <= '0;
    end else if (cfg_wr_en) begin
      k_rate_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_r  <= in_req_type;
      time_r <= in_arrival_time;
      name_r <= in_patient_name;
      sev_r  <= in_severity;
    end
  end

  // ---- aged priority: severity - k_rate * arrival_time ----
  apqr_prio u_prio (
    .clk      (clk),
    .k_rate   (k_rate_r),
    .arr_time (time_r),
    .severity (sev_r),
    .prio     (new_prio)
  );

  assign new_entry = '{valid: 1'b1, prio: new_prio, name: name_r};

  // ---- cell chain ----
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t lft, rgt;

    if (i == 0) begin : g_first
      assign lft = ENTRY_NONE;
    end else begin : g_mid_l
      assign lft = ent[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign rgt = ENTRY_NONE;
    end else begin : g_mid_r
      assign rgt = ent[i+1];
    end

    assign valid_vec[i] = ent[i].valid;
    assign match_vec[i] = flags[i].match;
    assign beat_vec[i]  = flags[i].beat;

    // insert: first beaten cell loads the new key, cells behind it shift right;
    // serve and leave: cells from the removed one onward pull from the right
    always_comb begin
      cmd[i] = CMD_HOLD;
      if (do_insert && beat_vec[i]) begin
        cmd[i] = beat_lag[i] ? CMD_LEFT : CMD_NEW;
      end else if (do_serve || (do_leave && (|match_vec[i:0]))) begin
        cmd[i] = CMD_RIGHT;
      end
    end

    apqr_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .cmd         (cmd[i]),
      .new_entry   (new_entry),
      .left_entry  (lft),
      .right_entry (rgt),
      .entry       (ent[i]),
      .flags       (flags[i])
    );
  end

  assign beat_lag = {beat_vec[CAPACITY-2:0], 1'b0};

  // ---- apply-step decisions ----
  assign dup  = |match_vec;              // names are unique, so at most one hit
  assign full = valid_vec[CAPACITY-1];   // packed chain: last cell set means full

  assign need_result = (req_r == REQ_SERVE) || ((req_r == REQ_ARRIVE) && (dup || full));
  assign blocked     = need_result && out_valid_r && !out_ready;

  always_comb begin
    state_nxt    = state_r;
    do_insert    = 1'b0;
    do_serve     = 1'b0;
    do_leave     = 1'b0;
    out_load     = 1'b0;
    out_kind_nxt = RES_SERVED;
    out_name_nxt = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            REQ_ARRIVE: state_nxt = S_MUL;
            REQ_SERVE:  state_nxt = S_APPLY;
            REQ_LEAVE:  state_nxt = S_CMP;
            default:    state_nxt = S_IDLE;   // unused code: dropped
          endcase
        end
      end
      S_MUL: state_nxt = S_SUB;
      S_SUB: state_nxt = S_CMP;
      S_CMP: state_nxt = S_APPLY;
      S_APPLY: begin
        if (!blocked) begin
          state_nxt = S_IDLE;
          out_load  = need_result;
          if (req_r == REQ_ARRIVE) begin
            if (dup) begin
              out_kind_nxt = RES_DUP;
            end else if (full) begin
              out_kind_nxt = RES_FULL;
            end else begin
              do_insert = 1'b1;
            end
          end else if (req_r == REQ_SERVE) begin
            if (ent[0].valid) begin
              out_kind_nxt = RES_SERVED;
              out_name_nxt = ent[0].name;
              do_serve     = 1'b1;
            end else begin
              out_kind_nxt = RES_EMPTY;
            end
          end else begin
            do_leave = 1'b1;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_kind_r <= out_kind_nxt;
      out_name_r <= out_name_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_kind = out_kind_r;
  assign out_served_name = out_name_r;

`ifndef SYNTHESIS
  // occupied cells always form an unbroken run starting at cell 0
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    ((valid_vec + 1'b1) & valid_vec) == '0)
    else $error("cell chain has a gap");

  // stored names stay unique, so a name compare never hits twice
  a_unique: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(match_vec))
    else $error("name found in more than one cell");

  // a shifting insert must never push an entry off the end of the chain
  a_no_spill: assert property (@(posedge clk) disable iff (!rst_n)
    do_insert |-> !full)
    else $error("insert into a full chain");

  // only a served result carries a name
  a_name_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_result_kind != RES_SERVED)) |-> (out_served_name == '0))
    else $error("name on a non-served result");
`endif

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps

module testbench import apqr_pkg::*;;

  localparam int CAPACITY = 64;
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;  // no-op code, block ignores it
  localparam int POOL_SIZE = 128;                  // more names than slots, so full is reached

  // request mix used by one burst of random traffic
  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} mix_t;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [NAME_W-1:0] nm;
  } result_t;

  // Scoreboard: keeps its own copy of the queue and k_rate, and a FIFO of
  // results owed by the block.
  class triage_queue_model;
    bit [K_W-1:0]    k_rate;
    bit              occupied [CAPACITY];
    longint          prio_of [CAPACITY];
    bit [NAME_W-1:0] name_of [CAPACITY];
    result_t         due [$];
    int              fail_count;

    function int slot_of(logic [NAME_W-1:0] nm);
      for (int i = 0; i < CAPACITY; i++)
        if (occupied[i] && name_of[i] == nm) return i;
      return -1;
    endfunction

    function bit [NAME_W-1:0] random_stored_name();
      int live [$];
      foreach (occupied[i]) if (occupied[i]) live.push_back(i);
      if (live.size() == 0) return {$urandom, $urandom};
      return name_of[live[$urandom_range(live.size() - 1)]];
    endfunction

    function void report(string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
    endfunction

    function void take_request(logic [REQ_W-1:0] req, logic [TIME_W-1:0] t,
                               logic [NAME_W-1:0] nm, logic [SEV_W-1:0] sev);
      int slot;
      longint aged;
      longint base;
      slot = -1;
      case (req)
        REQ_ARRIVE: begin
          if (slot_of(nm) >= 0) begin
            due.push_back('{RES_DUP, '0});
          end else begin
            for (int i = 0; i < CAPACITY; i++)
              if (!occupied[i] && slot < 0) slot = i;
            if (slot < 0) begin
              due.push_back('{RES_FULL, '0});
            end else begin
              aged = k_rate;
              aged = aged * t;  // below 2^56
              base = sev;
              occupied[slot] = 1'b1;
              name_of[slot]  = nm;
              prio_of[slot]  = base - aged;
            end
          end
        end
        REQ_SERVE: begin
          for (int i = 0; i < CAPACITY; i++) begin
            if (occupied[i] && (slot < 0 || prio_of[i] > prio_of[slot] ||
                (prio_of[i] == prio_of[slot] && name_of[i] < name_of[slot])))
              slot = i;
          end
          if (slot < 0) begin
            due.push_back('{RES_EMPTY, '0});
          end else begin
            due.push_back('{RES_SERVED, name_of[slot]});
            occupied[slot] = 1'b0;
          end
        end
        REQ_LEAVE: begin
          slot = slot_of(nm);
          if (slot >= 0) occupied[slot] = 1'b0;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [KIND_W-1:0] kind, logic [NAME_W-1:0] nm);
      result_t owed;
      if (due.size() == 0) begin
        report($sformatf("unexpected result: kind %0d name %h", kind, nm));
        return;
      end
      owed = due.pop_front();
      if (kind !== owed.kind || nm !== owed.nm)
        report($sformatf("result mismatch: kind exp %0d got %0d, name exp %h got %h",
                         owed.kind, kind, owed.nm, nm));
    endfunction
  endclass

  logic              clk;
  logic              rst_n           = 1'b0;
  logic              in_valid        = 1'b0;
  logic              in_ready;
  logic [REQ_W-1:0]  in_req_type     = REQ_SERVE;
  logic [TIME_W-1:0] in_arrival_time = '0;
  logic [NAME_W-1:0] in_patient_name = '0;
  logic [SEV_W-1:0]  in_severity     = '0;
  logic              out_valid;
  logic              out_ready       = 1'b0;
  logic [KIND_W-1:0] out_result_kind;
  logic [NAME_W-1:0] out_served_name;
  logic              cfg_wr_en       = 1'b0;
  logic [K_W-1:0]    cfg_wr_data     = '0;

  triage_queue_model triage;
  bit [NAME_W-1:0]   name_pool [POOL_SIZE];
  int                send_idle_pct;
  int                recv_idle_pct;

  aging_priority_queue_with_removal #(.CAPACITY(CAPACITY)) uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_req_type     (in_req_type),
    .in_arrival_time (in_arrival_time),
    .in_patient_name (in_patient_name),
    .in_severity     (in_severity),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_result_kind (out_result_kind),
    .out_served_name (out_served_name),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data)
  );

  // 2 ns clock
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Receiver: ready is re-rolled every falling edge, so stalls land on every
  // phase of the block's work; results are checked at the rising edge.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid === 1'b1 && out_ready)
      triage.check_result(out_result_kind, out_served_name);
  end

  // Small values make ties likely; all-ones and full-range values toggle every bit.
  function automatic logic [TIME_W-1:0] pick_time();
    case ($urandom_range(9)) inside
      [0:2]:   return $urandom_range(3);
      3:       return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [SEV_W-1:0] pick_severity();
    case ($urandom_range(9)) inside
      [0:2]:   return SEV_W'($urandom_range(3));
      3:       return '1;
      default: return SEV_W'($urandom_range(24'hFFFFFF));
    endcase
  endfunction

  // One request transfer. Entered and left at a falling edge; the sender
  // may idle first, then holds valid and payload until the transfer.
  task automatic offer_request(input logic [REQ_W-1:0] req, input logic [TIME_W-1:0] t,
                               input logic [NAME_W-1:0] nm, input logic [SEV_W-1:0] sev);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_req_type     <= req;
    in_arrival_time <= t;
    in_patient_name <= nm;
    in_severity     <= sev;
    do @(posedge clk); while (in_ready !== 1'b1);
    triage.take_request(req, t, nm, sev);
    @(negedge clk);
  endtask

  // k_rate is only written with the block idle: every owed result is in,
  // and arrivals/leaves (no result) have had time to finish.
  task automatic set_aging_rate(input logic [K_W-1:0] value);
    in_valid <= 1'b0;
    while (triage.due.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(negedge clk);
    triage.k_rate = value;
    cfg_wr_en <= 1'b0;
  endtask

  // Random traffic in bursts: fill bursts push the store to full, drain
  // bursts empty it, even bursts mix. Leaves and duplicate arrivals mostly
  // use names that are stored right now, so they actually hit.
  task automatic run_random(input int count);
    int   n;
    int   roll;
    int   burst_left;
    int   arrive_cut;
    int   serve_cut;
    mix_t mix;
    logic [REQ_W-1:0]  req;
    logic [NAME_W-1:0] nm;
    n          = 0;
    burst_left = 0;
    mix        = MIX_EVEN;
    while (n < count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(20, 80);
        roll = $urandom_range(99);
        mix  = (roll < 45) ? MIX_FILL : (roll < 70) ? MIX_DRAIN : MIX_EVEN;
      end
      burst_left--;
      case (mix)
        MIX_FILL:  begin arrive_cut = 80; serve_cut = 90; end
        MIX_DRAIN: begin arrive_cut = 25; serve_cut = 75; end
        default:   begin arrive_cut = 45; serve_cut = 72; end
      endcase
      roll = $urandom_range(99);
      req  = (roll < arrive_cut) ? REQ_ARRIVE :
             (roll < serve_cut)  ? REQ_SERVE  :
             (roll < 97)         ? REQ_LEAVE  : REQ_UNUSED;
      roll = $urandom_range(99);
      if ((req == REQ_ARRIVE && roll < 20) || (req == REQ_LEAVE && roll < 55))
        nm = triage.random_stored_name();
      else if (roll < 85)
        nm = name_pool[$urandom_range(POOL_SIZE - 1)];
      else
        nm = {$urandom, $urandom};
      offer_request(req, pick_time(), nm, pick_severity());
      if (req != REQ_UNUSED) n++;
    end
  endtask

  initial begin
    bit [NAME_W-1:0] shared;
    triage = new();
    send_idle_pct = 24;
    recv_idle_pct = 45;

    // Name pool: random keys, keys that differ only in the last byte or the
    // low word (order decided late in the compare), and zero-padded short keys.
    shared = {$urandom, $urandom};
    for (int i = 0; i < POOL_SIZE; i++) begin
      case (i % 4)
        0:       name_pool[i] = {$urandom, $urandom};
        1:       name_pool[i] = {shared[63:8], 8'(i)};
        2:       name_pool[i] = {$urandom, 32'd0};
        default: name_pool[i] = {shared[63:32], $urandom};
      endcase
    end

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part, k_rate = 1 so priority is severity minus time.
    set_aging_rate(24'd1);
    offer_request(REQ_SERVE,  32'd0, 64'd0, 24'd0);           // serve on empty queue
    offer_request(REQ_LEAVE,  32'd0, 64'd0, 24'd0);           // leave, name absent
    offer_request(REQ_UNUSED, '1, '1, '1);                    // unused code, no effect
    offer_request(REQ_ARRIVE, 32'd0, 64'd0, 24'd0);           // all-zero arrival
    offer_request(REQ_ARRIVE, '1, '1, '1);                    // extremes, most negative age
    offer_request(REQ_ARRIVE, 32'd7, 64'd0, 24'd9);           // duplicate of name zero
    offer_request(REQ_ARRIVE, 32'd10, 64'h414C494345000000, 24'd20);  // "ALICE", prio 10
    offer_request(REQ_ARRIVE, 32'd5, 64'h414C494300000000, 24'd15);   // "ALIC", tie at 10
    offer_request(REQ_ARRIVE, 32'd0, 64'h424F420000000000, 24'd10);   // "BOB", tie at 10
    offer_request(REQ_LEAVE,  32'd0, 64'h424F420000000000, 24'd0);    // leave, present
    offer_request(REQ_LEAVE,  32'd0, 64'h424F420000000000, 24'd0);    // leave, now absent
    repeat (5) offer_request(REQ_SERVE, '1, '1, '1);          // drain in rank order
    offer_request(REQ_SERVE,  32'd0, 64'd0, 24'd0);           // empty again
    offer_request(REQ_ARRIVE, 32'd0, 64'h424F420000000000, 24'd0);   // re-arrival after leave
    offer_request(REQ_SERVE,  32'd0, 64'd0, 24'd0);

    // Random phases; the store carries over from phase to phase.
    set_aging_rate(24'd0);
    run_random(330);

    send_idle_pct = 45;
    recv_idle_pct = 24;
    set_aging_rate(24'hFFFFFF);
    run_random(330);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_aging_rate(K_W'($urandom_range(2, 255)));
    run_random(170);
    set_aging_rate(K_W'($urandom_range(24'hFFFFFF)));
    run_random(170);

    in_valid <= 1'b0;
    while (triage.due.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (triage.fail_count == 0 && triage.due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: set far beyond the slowest correct run.
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
src/apqr_pkg.sv
src/apqr_prio.sv
src/apqr_cell.sv
src/aging_priority_queue_with_removal.sv
tb/testbench.sv
